// ===== rtl/interlaced_led_matrix_scanner_unit_assert.svh =====
// Assertion macros shared by the scanner RTL.
// Each use expects clk and arst_n in scope; no other dependencies.
`ifndef INTERLACED_LED_MATRIX_SCANNER_UNIT_ASSERT_SVH
`define INTERLACED_LED_MATRIX_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define ILMS_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// next-cycle implication
`define ILMS_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

// ===== rtl/ilms_pkg.sv =====
// Shared types and codes for the interlaced LED matrix scanner.
// No dependencies; every other file but the assertion header imports it.
package ilms_pkg;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// scan segments within one row
	localparam logic [1:0] SEG_COL    = 2'd0;
	localparam logic [1:0] SEG_ROW    = 2'd1;
	localparam logic [1:0] SEG_STROBE = 2'd2;

	// phases of one shifted bit
	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_RISE = 2'd1;
	localparam logic [1:0] PH_FALL = 2'd2;

	localparam int ROW_BITS     = 2;
	localparam int STROBE_STEPS = 8;

	typedef struct packed {
		logic       command;
		logic [6:0] byte_index;
		logic [7:0] byte_value;
	} item_word_t;

	typedef struct packed {
		logic       col_data;
		logic       col_clock;
		logic       col_latch;
		logic       col_enable;
		logic       row_data;
		logic       row_clock;
		logic       row_latch;
		logic       row_enable;
		logic [4:0] current_row;
	} result_word_t;

	// one decoded scan step
	typedef struct packed {
		logic [1:0] seg;
		logic [1:0] ph;
		logic [2:0] sub;          // bit within byte, or strobe position
		logic       row_bit;
		logic [4:0] current_row;
	} step_t;

endpackage

// ===== rtl/ilms_item_if.sv =====
// Input channel of the scanner: valid/ready plus one item word.
// Depends on ilms_pkg.
interface ilms_item_if;
	import ilms_pkg::*;

	logic       valid;
	logic       ready;
	item_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ilms_result_if.sv =====
// Result channel of the scanner: valid/ready plus one pin-level word.
// Depends on ilms_pkg.
interface ilms_result_if;
	import ilms_pkg::*;

	logic         valid;
	logic         ready;
	result_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ilms_frame_store.sv =====
// Frame byte memory with per-entry valid bits cleared at reset.
// Depends on ilms_pkg; read data is registered, valid in the next cycle.
module ilms_frame_store #(
	parameter int DEPTH = 72,
	parameter int AXW   = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [6:0]     wr_index,
	input  logic [7:0]     wr_value,
	input  logic           rd_en,
	input  logic [AXW-1:0] rd_addr,
	output logic [7:0]     rd_byte
);
	import ilms_pkg::*;

	localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_s1;
	logic             ok_s1;
	logic             wr_hit;
	logic             rd_hit;

	assign wr_hit = wr_en && ({1'b0, wr_index} < 8'(DEPTH));
	assign rd_hit = (32'(rd_addr) < 32'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_hit)
			mem[wr_index[MAW-1:0]] <= wr_value;
		if (rd_en)
			rd_s1 <= mem[rd_addr[MAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ok_s1   <= 1'b0;
		end else begin
			if (wr_hit)
				valid_q[wr_index[MAW-1:0]] <= 1'b1;
			if (rd_en)
				ok_s1 <= rd_hit && valid_q[rd_addr[MAW-1:0]];
		end
	end

	// unwritten or out-of-frame entries read as dark
	assign rd_byte = ok_s1 ? rd_s1 : 8'h00;

endmodule

// ===== rtl/ilms_sequencer.sv =====
// Row and step counters of the scan; decodes the current step and the
// frame byte address. Depends on ilms_pkg and the assertion macros.
`include "interlaced_led_matrix_scanner_unit_assert.svh"

module ilms_sequencer #(
	parameter int ROWS = 24,
	parameter int COLS = 24,
	parameter int AXW  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	output ilms_pkg::step_t step,
	output logic [AXW-1:0] addr
);
	import ilms_pkg::*;

	localparam int BPR = (COLS + 7) / 8;
	localparam int RW  = $clog2(ROWS);
	localparam int KW  = $clog2(COLS) + 1;
	localparam int XW  = RW + 5;

	logic [RW-1:0] row_q;
	logic [1:0]    seg_q;
	logic [1:0]    ph_q;
	logic [KW-1:0] idx_q;
	logic [RW:0]   row_p2;
	logic [RW-1:0] row_next;
	logic [XW-1:0] row_x;
	logic          row_end;

	assign row_p2 = {1'b0, row_q} + (RW+1)'(2);

	// even rows first, then odd rows, then wrap to row 0
	always_comb begin
		if (row_q == RW'(ROWS - 2))
			row_next = RW'(1);
		else if (row_p2 >= (RW+1)'(ROWS))
			row_next = '0;
		else
			row_next = row_p2[RW-1:0];
	end

	assign row_end = (seg_q == SEG_STROBE) && (idx_q == KW'(STROBE_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			seg_q <= SEG_COL;
			ph_q  <= PH_DATA;
			idx_q <= '0;
		end else if (advance) begin
			unique case (seg_q) inside
				SEG_COL, SEG_ROW: begin
					if (ph_q == PH_FALL) begin
						ph_q <= PH_DATA;
						if (seg_q == SEG_COL && idx_q == KW'(COLS - 1)) begin
							seg_q <= SEG_ROW;
							idx_q <= '0;
						end else if (seg_q == SEG_ROW && idx_q == KW'(ROW_BITS - 1)) begin
							seg_q <= SEG_STROBE;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + KW'(1);
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				SEG_STROBE: begin
					if (row_end) begin
						seg_q <= SEG_COL;
						idx_q <= '0;
						row_q <= row_next;
					end else begin
						idx_q <= idx_q + KW'(1);
					end
				end
				default: begin
					seg_q <= SEG_COL;
					ph_q  <= PH_DATA;
					idx_q <= '0;
				end
			endcase
		end
	end

	assign row_x = XW'(row_q);

	always_comb begin
		step.seg         = seg_q;
		step.ph          = ph_q;
		step.sub         = idx_q[2:0];
		step.current_row = row_x[4:0];
		if (row_q == RW'(0))
			step.row_bit = idx_q[0];
		else if (row_q == RW'(1))
			step.row_bit = ~idx_q[0];
		else
			step.row_bit = 1'b0;
	end

	// bytes of a row go out last byte first
	assign addr = AXW'(row_q) * AXW'(BPR) + AXW'(BPR - 1) - AXW'(idx_q[KW-1:3]);

	`ILMS_ASSERT_IMP(a_row_range, 1'b1, 32'(row_q) < 32'(ROWS), "row counter out of range")
	`ILMS_ASSERT_IMP(a_strobe_phase, seg_q == SEG_STROBE, ph_q == PH_DATA, "phase set in strobe")
	`ILMS_ASSERT_NXT(a_row_hold, !(advance && row_end), $stable(row_q), "row moved mid-row")

endmodule

// ===== rtl/ilms_pin_stage.sv =====
// Step register, pin-level update and result register of the scanner.
// Depends on ilms_pkg, ilms_result_if and the assertion macros.
`include "interlaced_led_matrix_scanner_unit_assert.svh"

module ilms_pin_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick,
	input  ilms_pkg::step_t step,
	input  logic [7:0]      pix_byte,
	output logic            free,
	ilms_result_if.source   result
);
	import ilms_pkg::*;

	localparam int P_CDATA = 0;
	localparam int P_CCLK  = 1;
	localparam int P_CLAT  = 2;
	localparam int P_CEN   = 3;
	localparam int P_RDATA = 4;
	localparam int P_RCLK  = 5;
	localparam int P_RLAT  = 6;
	localparam int P_REN   = 7;

	localparam logic [2:0] STB_REN_HI  = 3'd0;
	localparam logic [2:0] STB_CEN_HI  = 3'd1;
	localparam logic [2:0] STB_RLAT_LO = 3'd2;
	localparam logic [2:0] STB_RLAT_HI = 3'd3;
	localparam logic [2:0] STB_CLAT_LO = 3'd4;
	localparam logic [2:0] STB_CLAT_HI = 3'd5;
	localparam logic [2:0] STB_CEN_LO  = 3'd6;
	localparam logic [2:0] STB_REN_LO  = 3'd7;

	logic         tick_s1;
	step_t        step_s1;
	logic [7:0]   pins_q;
	logic [7:0]   pins_next;
	logic         out_valid_q;
	result_word_t word_q;
	logic         s1_move;
	logic         out_free;

	assign out_free = !out_valid_q || result.ready;
	assign s1_move  = tick_s1 && out_free;
	assign free     = !tick_s1 || s1_move;

	always_comb begin
		pins_next = pins_q;
		unique case (step_s1.seg)
			SEG_COL: begin
				if (step_s1.ph == PH_DATA)
					pins_next[P_CDATA] = ~pix_byte[step_s1.sub];
				else
					pins_next[P_CCLK] = (step_s1.ph == PH_RISE);
			end
			SEG_ROW: begin
				if (step_s1.ph == PH_DATA)
					pins_next[P_RDATA] = step_s1.row_bit;
				else
					pins_next[P_RCLK] = (step_s1.ph == PH_RISE);
			end
			SEG_STROBE: begin
				case (step_s1.sub)
					STB_REN_HI:  pins_next[P_REN]  = 1'b1;
					STB_CEN_HI:  pins_next[P_CEN]  = 1'b1;
					STB_RLAT_LO: pins_next[P_RLAT] = 1'b0;
					STB_RLAT_HI: pins_next[P_RLAT] = 1'b1;
					STB_CLAT_LO: pins_next[P_CLAT] = 1'b0;
					STB_CLAT_HI: pins_next[P_CLAT] = 1'b1;
					STB_CEN_LO:  pins_next[P_CEN]  = 1'b0;
					default:     pins_next[P_REN]  = 1'b0;
				endcase
			end
			default: pins_next = pins_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1     <= 1'b0;
			pins_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (free)
				tick_s1 <= tick;
			if (s1_move)
				pins_q <= pins_next;
			if (out_free)
				out_valid_q <= tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && tick)
			step_s1 <= step;
		if (s1_move) begin
			word_q.col_data    <= pins_next[P_CDATA];
			word_q.col_clock   <= pins_next[P_CCLK];
			word_q.col_latch   <= pins_next[P_CLAT];
			word_q.col_enable  <= pins_next[P_CEN];
			word_q.row_data    <= pins_next[P_RDATA];
			word_q.row_clock   <= pins_next[P_RCLK];
			word_q.row_latch   <= pins_next[P_RLAT];
			word_q.row_enable  <= pins_next[P_REN];
			word_q.current_row <= step_s1.current_row;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = word_q;

	`ILMS_ASSERT_NXT(a_step_held, tick_s1 && !out_free, tick_s1, "pending step dropped")
	`ILMS_ASSERT_IMP(a_one_pin, s1_move, $countones(pins_next ^ pins_q) <= 1, "multi-pin step")
	`ILMS_ASSERT_IMP(a_strobe_end,
		s1_move && step_s1.seg == SEG_STROBE && step_s1.sub == STB_REN_LO,
		!pins_next[P_REN] && !pins_next[P_CEN], "outputs left disabled after strobe")

endmodule

// ===== rtl/interlaced_led_matrix_scanner_unit.sv =====
// Top level of the interlaced LED matrix scanner.
// Depends on ilms_pkg, both channel interfaces, the frame store, the
// sequencer and the pin stage.
//
// The block takes one word per clock while ready is high. A write word
// stores a frame byte at once and gives no result; a write beyond the
// frame is dropped. A tick word makes one pin change of the row scan and
// its result, all eight pin levels and the row, passes through the frame
// store read register, beside the step register, and then the result
// register. With the result side always ready the sustained rate is one
// word per cycle; a stalled result holds the pipeline and input ready
// falls once the step register is also full. The frame store reads as
// all zero after reset through per-byte valid bits, so there is no
// clearing pass and the block is ready straight out of reset.
module interlaced_led_matrix_scanner_unit #(
	parameter int ROWS = 24,
	parameter int COLS = 24
) (
	input logic           clk,
	input logic           arst_n,
	ilms_item_if.sink     item,
	ilms_result_if.source result
);
	import ilms_pkg::*;

	localparam int BPR   = (COLS + 7) / 8;
	localparam int STORE = ROWS * BPR;
	localparam int DEPTH = (STORE < 128) ? STORE : 128;
	localparam int AXW   = $clog2(STORE) + 1;

	logic           accept;
	logic           tick;
	logic           wr_en;
	logic           free;
	step_t          step;
	logic [AXW-1:0] addr;
	logic [7:0]     pix_byte;

	assign item.ready = free;
	assign accept     = item.valid && free;
	assign tick       = accept && (item.data.command == CMD_TICK);
	assign wr_en      = accept && (item.data.command == CMD_WRITE);

	ilms_sequencer #(
		.ROWS (ROWS),
		.COLS (COLS),
		.AXW  (AXW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (tick),
		.step    (step),
		.addr    (addr)
	);

	ilms_frame_store #(
		.DEPTH (DEPTH),
		.AXW   (AXW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (item.data.byte_index),
		.wr_value (item.data.byte_value),
		.rd_en    (tick),
		.rd_addr  (addr),
		.rd_byte  (pix_byte)
	);

	ilms_pin_stage u_pins (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.step     (step),
		.pix_byte (pix_byte),
		.free     (free),
		.result   (result)
	);

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for interlaced_led_matrix_scanner_unit: frame writes and scan ticks
// go in, and every pin-level word that comes out is checked against an in-bench scan model.
// Depends on ilms_pkg, ilms_item_if, ilms_result_if and the scanner unit.
`timescale 1ns / 1ps

import ilms_pkg::*;

localparam int SCAN_ROWS     = 24;
localparam int SCAN_COLS     = 24;
localparam int BYTES_PER_ROW = (SCAN_COLS + 7) / 8;
localparam int STORE_BYTES   = SCAN_ROWS * BYTES_PER_ROW;
localparam int COL_STEPS     = 3 * SCAN_COLS;
localparam int ROW_STEPS     = 3 * ROW_BITS;
localparam int STEPS_PER_ROW = COL_STEPS + ROW_STEPS + STROBE_STEPS;

class scan_scoreboard;
	bit [7:0]     frame_bytes [STORE_BYTES];
	int unsigned  scan_row;
	int unsigned  scan_step;
	result_word_t pin_state;
	result_word_t expected_pins [$];
	bit [SCAN_ROWS-1:0] rows_seen;
	int unsigned  ticks, writes, dropped, checked, errors;

	function new();
		foreach (frame_bytes[i])
			frame_bytes[i] = '0;
		scan_row  = 0;
		scan_step = 0;
		pin_state = '0;
		rows_seen = '0;
		ticks = 0; writes = 0; dropped = 0; checked = 0; errors = 0;
	endfunction

	function int pending();
		return expected_pins.size();
	endfunction

	// One pin change of the scan, then advance step and, at the end of a row, the row.
	function result_word_t scan_advance();
		int unsigned  s, k, ph, addr;
		result_word_t r;
		r = pin_state;
		s = scan_step;
		if (s < COL_STEPS) begin
			k  = s / 3;
			ph = s % 3;
			if (ph == PH_DATA) begin
				// bytes go out last first, each LSB first
				addr = scan_row * BYTES_PER_ROW + (BYTES_PER_ROW - 1 - k / 8);
				r.col_data = ~frame_bytes[addr][k % 8];
			end else begin
				r.col_clock = (ph == PH_RISE);
			end
		end else if (s < COL_STEPS + ROW_STEPS) begin
			s  = s - COL_STEPS;
			ph = s % 3;
			if (ph == PH_DATA)
				r.row_data = (scan_row == 0 && s / 3 == 1) || (scan_row == 1 && s / 3 == 0);
			else
				r.row_clock = (ph == PH_RISE);
		end else begin
			// strobe position within the row
			case (s - COL_STEPS - ROW_STEPS)
				0: r.row_enable = 1'b1;
				1: r.col_enable = 1'b1;
				2: r.row_latch  = 1'b0;
				3: r.row_latch  = 1'b1;
				4: r.col_latch  = 1'b0;
				5: r.col_latch  = 1'b1;
				6: r.col_enable = 1'b0;
				default: r.row_enable = 1'b0;
			endcase
		end
		r.current_row = scan_row[4:0];
		rows_seen[scan_row] = 1'b1;
		pin_state = r;
		scan_step++;
		if (scan_step >= STEPS_PER_ROW) begin
			scan_step = 0;
			if (scan_row == SCAN_ROWS - 2)
				scan_row = 1;
			else if (scan_row + 2 >= SCAN_ROWS)
				scan_row = 0;
			else
				scan_row = scan_row + 2;
		end
		return r;
	endfunction

	function void note_word(item_word_t w);
		if (w.command == CMD_TICK) begin
			ticks++;
			expected_pins.push_back(scan_advance());
		end else if (w.byte_index < STORE_BYTES) begin
			writes++;
			frame_bytes[w.byte_index] = w.byte_value;
		end else begin
			dropped++;
		end
	endfunction

	task report_mismatch(string what);
		errors++;
		if (errors <= 40)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	task compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("tick result %0d: %s is %0d, expected %0d",
				checked, name, got, want));
	endtask

	task check_word(result_word_t got);
		result_word_t want;
		if (expected_pins.size() == 0) begin
			report_mismatch("pin word arrived with no tick outstanding");
			return;
		end
		want = expected_pins.pop_front();
		compare_field("col_data", got.col_data, want.col_data);
		compare_field("col_clock", got.col_clock, want.col_clock);
		compare_field("col_latch", got.col_latch, want.col_latch);
		compare_field("col_enable", got.col_enable, want.col_enable);
		compare_field("row_data", got.row_data, want.row_data);
		compare_field("row_clock", got.row_clock, want.row_clock);
		compare_field("row_latch", got.row_latch, want.row_latch);
		compare_field("row_enable", got.row_enable, want.row_enable);
		compare_field("current_row", got.current_row, want.current_row);
		checked++;
	endtask
endclass

module testbench;
	localparam int IDLE_LIMIT  = 3000;

	typedef enum {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_BURSTY} rx_mode_e;

	logic clk;
	logic arst_n;
	int   idle_cycles = 0;
	int   burst_left;

	scan_scoreboard sb;

	ilms_item_if   item_ch ();
	ilms_result_if result_ch ();

	interlaced_led_matrix_scanner_unit #(
		.ROWS (SCAN_ROWS),
		.COLS (SCAN_COLS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic item_word_t make_word(logic cmd, int unsigned idx, int unsigned val);
		item_word_t w;
		w.command    = cmd;
		w.byte_index = idx[6:0];
		w.byte_value = val[7:0];
		return w;
	endfunction

	// Drive one word in the current burst; when the burst is spent, start a new one, mostly after a gap.
	task automatic send_word(item_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	// accepted words in both directions, and the no-progress counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_word(item_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_word(result_ch.data);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// result side: switch at random between stall patterns
	initial begin
		rx_mode_e mode;
		int       mode_left;
		int       hold_left;
		result_ch.ready = 1'b0;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				RX_OPEN:   result_ch.ready <= 1'b1;
				RX_TOGGLE: result_ch.ready <= ~result_ch.ready;
				RX_RANDOM: result_ch.ready <= ($urandom_range(0, 9) < 7);
				default: begin
					if (hold_left > 0) begin
						hold_left--;
						result_ch.ready <= 1'b0;
					end else begin
						result_ch.ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							hold_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	initial begin
		int unsigned n, run_len, row_sel, idx;
		sb = new();
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		burst_left      = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// tick on the cleared frame, then edge writes including two past the frame
		send_word(make_word(CMD_TICK, 0, 0));
		send_word(make_word(CMD_WRITE, 2, 8'hA5));
		send_word(make_word(CMD_WRITE, 1, 8'hFF));
		send_word(make_word(CMD_WRITE, 0, 8'h00));
		send_word(make_word(CMD_WRITE, STORE_BYTES - 1, 8'h80));
		send_word(make_word(CMD_WRITE, STORE_BYTES, 8'h5A));
		send_word(make_word(CMD_WRITE, 127, 8'hFF));
		send_word(make_word(CMD_WRITE, 3, 8'h01));
		send_word(make_word(CMD_WRITE, 70, 8'h7F));
		repeat (16)
			send_word(make_word(CMD_TICK, 127, 8'hFF));

		// mostly runs of ticks, with row writes landing mid-scan
		n = 0;
		while (n < 700) begin
			if ($urandom_range(0, 9) < 8) begin
				run_len = $urandom_range(1, 12);
				repeat (run_len) begin
					send_word(make_word(CMD_TICK, $urandom_range(0, 127),
						$urandom_range(0, 255)));
					n++;
				end
			end else begin
				row_sel = $urandom_range(0, SCAN_ROWS - 1);
				run_len = $urandom_range(1, BYTES_PER_ROW);
				for (int b = 0; b < run_len; b++) begin
					idx = row_sel * BYTES_PER_ROW + b;
					if ($urandom_range(0, 9) == 0)
						idx = $urandom_range(STORE_BYTES, 127);
					send_word(make_word(CMD_WRITE, idx, $urandom_range(0, 255)));
					if (idx < STORE_BYTES)
						n++;
				end
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d pin words over %0d of %0d rows; %0d frame writes, %0d dropped.",
			sb.checked, $countones(sb.rows_seen), SCAN_ROWS, sb.writes, sb.dropped);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ilms_pkg.sv
rtl/ilms_item_if.sv
rtl/ilms_result_if.sv
rtl/ilms_frame_store.sv
rtl/ilms_sequencer.sv
rtl/ilms_pin_stage.sv
rtl/interlaced_led_matrix_scanner_unit.sv
test/testbench.sv
